// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the trip average-speed block.
// Each macro checks on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/tasc_pkg.sv =====
// Shared types and constants of the trip average-speed block.
// No dependencies; used by tasc_div and trip_average_speed_calc.
`timescale 1ns / 1ps

package tasc_pkg;

  localparam int DATA_W   = 32;
  localparam int SPEED_W  = 16;
  localparam int TIME_W   = 19;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] DEFAULT_UPDATE_TICKS    = 16'd300;
  localparam logic [DATA_W-1:0]   DEFAULT_TIME_WRAP_TICKS = 32'd3600000;
  // Travel ticks are 100 ms, shown in seconds.
  localparam logic [DATA_W-1:0]   TICKS_PER_SECOND        = 32'd10;

  localparam logic [DATA_W-1:0]  THRESHOLD_RST  = 32'd500;
  localparam logic [DATA_W-1:0]  MAX_DIST_RST   = 32'd100000000;
  localparam logic [DATA_W-1:0]  MAX_TIME_RST   = 32'd36000000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 16'd255;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RST_A = 2'd1,
    CMD_RST_B = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_MAX_DIST   = 2'd1,
    CFG_MAX_TIME   = 2'd2,
    CFG_MAX_SPEED  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               speed_ok;
    logic [TIME_W-1:0]  time_s;
    logic               time_ok;
  } pub_t;

endpackage

// ===== rtl/tasc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tasc_pkg for the default width.
`timescale 1ns / 1ps

module tasc_div
  import tasc_pkg::*;
#(
  parameter int W = DATA_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the shifted remainder when the subtract borrows
      quo_nxt  = {quo_r[W-2:0], ~diff[W]};
      rem_nxt  = diff[W] ? trial[W-1:0] : diff[W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/trip_average_speed_calc.sv =====
// Top level of the two-trip average-speed computer.
// Depends on tasc_pkg, tasc_div and assert_macros.svh.
//
//   port group | direction | handshake
//   in_*       | item in   | in_valid / in_stall
//   out_*      | result    | out_valid / out_stall
//   cfg_*      | reg write | cfg_we, no wait
//
// A tick with ignition on and a good signal, once initialised, goes from transfer
// through the apply, judge and divider-wait steps to the result register; the wait
// lasts until the 32-step serial dividers (one per trip for speed, one per trip for
// trip time) are done. Other items go from the apply step to the result register.
// Reset clears all trip state, published values and out_valid; registers get defaults.
// A new item is taken while the last result still waits; a stalled result
// holds the block in its final step until the transfer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trip_average_speed_calc
  import tasc_pkg::*;
#(
  parameter logic [PERIOD_W-1:0] UPDATE_TICKS    = DEFAULT_UPDATE_TICKS,
  parameter logic [DATA_W-1:0]   TIME_WRAP_TICKS = DEFAULT_TIME_WRAP_TICKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [DATA_W-1:0]    in_odo_meters,
  input  logic                 in_ignition_on,
  input  logic                 in_distance_signal_ok,
  input  logic                 in_wheel_frame_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SPEED_W-1:0]   out_speed_a,
  output logic                 out_speed_a_valid,
  output logic [SPEED_W-1:0]   out_speed_b,
  output logic                 out_speed_b_valid,
  output logic [TIME_W-1:0]    out_trip_time_a,
  output logic [TIME_W-1:0]    out_trip_time_b,
  output logic                 out_trip_time_valid,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_JUDGE,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [DATA_W-1:0]   odo_r, odo_nxt;
  logic                ign_r, ign_nxt;
  logic                sig_r, sig_nxt;
  logic                wheel_r, wheel_nxt;
  logic                init_r, init_nxt;

  logic [DATA_W-1:0]   dist_r [2];
  logic [DATA_W-1:0]   dist_nxt [2];
  logic [DATA_W-1:0]   off_r [2];
  logic [DATA_W-1:0]   off_nxt [2];
  logic [DATA_W-1:0]   drive_r [2];
  logic [DATA_W-1:0]   drive_nxt [2];
  logic [DATA_W-1:0]   travel_r [2];
  logic [DATA_W-1:0]   travel_nxt [2];
  logic [PERIOD_W-1:0] period_r [2];
  logic [PERIOD_W-1:0] period_nxt [2];
  logic [SPEED_W-1:0]  avg_r [2];
  logic [SPEED_W-1:0]  avg_nxt [2];
  logic [1:0]          avgv_r, avgv_nxt;
  pub_t                pub_r [2];
  pub_t                pub_nxt [2];
  logic [1:0]          spd_go_r, spd_go_nxt;
  logic [1:0]          tm_go_r, tm_go_nxt;

  logic [DATA_W-1:0]   thr_r, thr_nxt;
  logic [DATA_W-1:0]   maxd_r, maxd_nxt;
  logic [DATA_W-1:0]   maxt_r, maxt_nxt;
  logic [SPEED_W-1:0]  maxs_r, maxs_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]  out_speed_a_r, out_speed_b_r;
  logic                out_speed_a_valid_r, out_speed_b_valid_r;
  logic [TIME_W-1:0]   out_time_a_r, out_time_b_r;
  logic                out_time_valid_r;

  logic [1:0]          spd_start, tm_start;
  logic [3:0]          div_busy;
  logic [DATA_W-1:0]   spd_dvd [2];
  logic [DATA_W-1:0]   spd_q [2];
  logic [DATA_W-1:0]   tm_q [2];
  logic                out_load;
  logic                spd_pub_clear;

  // Per trip: a speed divider and a trip-time divider.
  for (genvar t = 0; t < 2; t++) begin : g_trip
    // distance * 36, wrapping at 32 bits
    assign spd_dvd[t] = (dist_r[t] << 5) + (dist_r[t] << 2);

    tasc_div #(.W(DATA_W)) u_spd_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (spd_start[t]),
      .dividend (spd_dvd[t]),
      .divisor  (drive_r[t]),
      .busy     (div_busy[t]),
      .quotient (spd_q[t])
    );

    tasc_div #(.W(DATA_W)) u_tm_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (tm_start[t]),
      .dividend (travel_r[t]),
      .divisor  (TICKS_PER_SECOND),
      .busy     (div_busy[2+t]),
      .quotient (tm_q[t])
    );
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    logic [PERIOD_W-1:0] per_inc [2];
    logic [1:0]          clr;

    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    odo_nxt    = odo_r;
    ign_nxt    = ign_r;
    sig_nxt    = sig_r;
    wheel_nxt  = wheel_r;
    init_nxt   = init_r;
    dist_nxt   = dist_r;
    off_nxt    = off_r;
    drive_nxt  = drive_r;
    travel_nxt = travel_r;
    period_nxt = period_r;
    avg_nxt    = avg_r;
    avgv_nxt   = avgv_r;
    pub_nxt    = pub_r;
    spd_go_nxt = spd_go_r;
    tm_go_nxt  = tm_go_r;
    spd_start  = '0;
    tm_start   = '0;
    clr        = '0;
    for (int t = 0; t < 2; t++) begin
      per_inc[t] = period_r[t] + PERIOD_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          odo_nxt   = in_odo_meters;
          ign_nxt   = in_ignition_on;
          sig_nxt   = in_distance_signal_ok;
          wheel_nxt = in_wheel_frame_ok;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_OUT;
        unique case (cmd_r) inside
          CMD_INIT: begin
            if (!init_r) begin
              init_nxt = 1'b1;
              clr      = 2'b11;
              for (int t = 0; t < 2; t++) begin
                pub_nxt[t].speed = '0;
              end
            end
          end
          CMD_RST_A, CMD_RST_B: begin
            if (init_r) begin
              clr = (cmd_r == CMD_RST_B) ? 2'b10 : 2'b01;
            end
          end
          CMD_TICK: begin
            if (init_r && ign_r) begin
              if (!sig_r) begin
                for (int t = 0; t < 2; t++) begin
                  pub_nxt[t] = '0;
                end
              end else begin
                for (int t = 0; t < 2; t++) begin
                  if (wheel_r) begin
                    if (odo_r > off_r[t]) begin
                      dist_nxt[t] = dist_r[t] + (odo_r - off_r[t]);
                      off_nxt[t]  = odo_r;
                    end
                    drive_nxt[t]  = drive_r[t] + DATA_W'(1);
                    travel_nxt[t] = travel_r[t] + DATA_W'(1);
                  end else begin
                    // stale wheel frame: drop the odometer step and restart the update period
                    off_nxt[t]    = odo_r;
                    period_nxt[t] = '0;
                  end
                end
                state_nxt = S_JUDGE;
              end
            end
          end
          default: ;
        endcase
        for (int t = 0; t < 2; t++) begin
          if (clr[t]) begin
            avg_nxt[t]    = '0;
            avgv_nxt[t]   = 1'b0;
            drive_nxt[t]  = '0;
            dist_nxt[t]   = '0;
            travel_nxt[t] = '0;
            period_nxt[t] = '0;
            off_nxt[t]    = odo_r;
          end
        end
      end
      S_JUDGE: begin
        for (int t = 0; t < 2; t++) begin
          if (per_inc[t] >= UPDATE_TICKS && dist_r[t] > thr_r) begin
            period_nxt[t] = '0;
            if (dist_r[t] <= maxd_r && drive_r[t] <= maxt_r && drive_r[t] != '0) begin
              spd_start[t] = 1'b1;
            end
          end else begin
            period_nxt[t] = per_inc[t];
          end
          if (travel_r[t] < TIME_WRAP_TICKS) begin
            tm_start[t] = 1'b1;
          end else begin
            travel_nxt[t] = '0;
          end
        end
        spd_go_nxt = spd_start;
        tm_go_nxt  = tm_start;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (div_busy == '0) begin
          for (int t = 0; t < 2; t++) begin
            if (spd_go_r[t]) begin
              if (spd_q[t] > {{(DATA_W-SPEED_W){1'b0}}, maxs_r}) begin
                avg_nxt[t] = maxs_r;
              end else begin
                avg_nxt[t] = spd_q[t][SPEED_W-1:0];
              end
              avgv_nxt[t] = 1'b1;
            end
            pub_nxt[t].speed    = avg_nxt[t];
            pub_nxt[t].speed_ok = avgv_nxt[t];
            pub_nxt[t].time_s   = tm_go_r[t] ? tm_q[t][TIME_W-1:0] : '0;
            pub_nxt[t].time_ok  = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Register writes.
  always_comb begin
    thr_nxt  = thr_r;
    maxd_nxt = maxd_r;
    maxt_nxt = maxt_r;
    maxs_nxt = maxs_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thr_nxt  = cfg_data;
        CFG_MAX_DIST:  maxd_nxt = cfg_data;
        CFG_MAX_TIME:  maxt_nxt = cfg_data;
        CFG_MAX_SPEED: maxs_nxt = cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Clear the result register once its transfer completes.
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THRESHOLD_RST;
      maxd_r      <= MAX_DIST_RST;
      maxt_r      <= MAX_TIME_RST;
      maxs_r      <= MAX_SPEED_RST;
      avgv_r      <= '0;
      spd_go_r    <= '0;
      tm_go_r     <= '0;
      for (int t = 0; t < 2; t++) begin
        dist_r[t]   <= '0;
        off_r[t]    <= '0;
        drive_r[t]  <= '0;
        travel_r[t] <= '0;
        period_r[t] <= '0;
        avg_r[t]    <= '0;
        pub_r[t]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      maxd_r      <= maxd_nxt;
      maxt_r      <= maxt_nxt;
      maxs_r      <= maxs_nxt;
      avgv_r      <= avgv_nxt;
      spd_go_r    <= spd_go_nxt;
      tm_go_r     <= tm_go_nxt;
      dist_r      <= dist_nxt;
      off_r       <= off_nxt;
      drive_r     <= drive_nxt;
      travel_r    <= travel_nxt;
      period_r    <= period_nxt;
      avg_r       <= avg_nxt;
      pub_r       <= pub_nxt;
    end
    cmd_r   <= cmd_nxt;
    odo_r   <= odo_nxt;
    ign_r   <= ign_nxt;
    sig_r   <= sig_nxt;
    wheel_r <= wheel_nxt;
    if (out_load) begin
      out_speed_a_r       <= pub_r[0].speed;
      out_speed_a_valid_r <= pub_r[0].speed_ok;
      out_speed_b_r       <= pub_r[1].speed;
      out_speed_b_valid_r <= pub_r[1].speed_ok;
      out_time_a_r        <= pub_r[0].time_s;
      out_time_b_r        <= pub_r[1].time_s;
      out_time_valid_r    <= pub_r[0].time_ok;
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_speed_a         = out_speed_a_r;
  assign out_speed_a_valid   = out_speed_a_valid_r;
  assign out_speed_b         = out_speed_b_r;
  assign out_speed_b_valid   = out_speed_b_valid_r;
  assign out_trip_time_a     = out_time_a_r;
  assign out_trip_time_b     = out_time_b_r;
  assign out_trip_time_valid = out_time_valid_r;

  assign spd_pub_clear = !pub_r[0].speed_ok && !pub_r[1].speed_ok &&
                         pub_r[0].speed == '0 && pub_r[1].speed == '0;

  // The published time of trip A only goes invalid together with every speed field.
  `ASSERT_IMPL(a_time_ok_guards_speed, !pub_r[0].time_ok, spd_pub_clear)
  // No divider runs once the block is back to waiting for an item.
  `ASSERT_IMPL(a_div_idle, state_r == S_IDLE, div_busy == '0)
  // A fresh result only ever comes out of the final step.
  `ASSERT_IMPL(a_result_from_out, $rose(out_valid_r), $past(state_r) == S_OUT)

endmodule
